[hw/rtl/alpbm_pkg.sv]
// ----------------------------------------------------------------------------
// alpbm_pkg: shared types, constants and helpers for the LED bar level meter
// Field widths, command and status bundles between controller and datapath,
// and the color accumulator arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

package alpbm_pkg;

   // Field and state widths
   localparam int SAMPLE_W    = 16;
   localparam int CFG_W       = 16;
   localparam int PEAK_W      = 16;
   localparam int LEVEL_W     = 19;   // Q3.16 smoothed level
   localparam int RECORD_W    = 20;   // Q4.16 level record
   localparam int ACC_W       = 26;   // Q9.16 signed color accumulator
   localparam int HEIGHT_W    = 7;
   localparam int COLOR_W     = 8;
   localparam int FRAC_W      = 16;
   localparam int STEP_W      = 16;
   localparam int DECAY_SHIFT = 24;   // decay_rate is Q0.24

   // Number of LEDs on the strip
   localparam int STRIP_LEDS  = 64;

   // Derived widths
   localparam int SUM_W       = LEVEL_W + 1;
   localparam int DPROD_W     = CFG_W + LEVEL_W;
   localparam int DECAY_W     = DPROD_W - DECAY_SHIFT;
   localparam int DIV_Q_W     = FRAC_W + 1;        // ratio quotient never exceeds 1.0 in Q1.16
   localparam int DIV_NUM_W   = LEVEL_W + FRAC_W;
   localparam int DIV_CNT_W   = $clog2(DIV_Q_W + 1);
   localparam int SPROD_W     = CFG_W + DIV_Q_W;

   localparam int COLOR_MAX   = 255;
   localparam logic [ACC_W-1:0] ACC_RED_RESET = ACC_W'(COLOR_MAX * (2 ** FRAC_W));

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_SILENCE_LEVEL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_SPEED    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_GAIN    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_RATE    = 2'd3;

   // Configuration reset values
   localparam logic [CFG_W-1:0] SILENCE_LEVEL_RESET = 16'd655;
   localparam logic [CFG_W-1:0] IDLE_SPEED_RESET    = 16'd328;
   localparam logic [CFG_W-1:0] SPEED_GAIN_RESET    = 16'd32768;
   localparam logic [CFG_W-1:0] DECAY_RATE_RESET    = 16'd1678;

   // Datapath operations issued by the controller states
   typedef enum logic [3:0] {
      OP_NONE,
      OP_EVAL,
      OP_DECAY_MUL,
      OP_DECAY_SUB,
      OP_LEVEL,
      OP_ZERO_RATIO,
      OP_DIV_LOAD,
      OP_DIV_STEP,
      OP_SAVE_RATIO,
      OP_SAVE_HEIGHT,
      OP_STEP_MUL,
      OP_ROT_R,
      OP_ROT_G,
      OP_ROT_B,
      OP_OUT_LOAD
   } dp_op_type;

   // Controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DECAY_MUL,
      ST_DECAY_SUB,
      ST_LEVEL,
      ST_DIV_CHECK,
      ST_DIV_RATIO,
      ST_SAVE_RATIO,
      ST_DIV_HEIGHT,
      ST_SAVE_HEIGHT,
      ST_STEP_MUL,
      ST_ROT_R,
      ST_ROT_G,
      ST_ROT_B,
      ST_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic      take;   // input item accepted this cycle
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic silent;      // peak and both history levels are zero
      logic quiet;       // smoothed level below the silence threshold
      logic rec_zero;    // level record is zero
      logic out_busy;    // output register full and stalled
   } dp_status_type;

   // Add or subtract a color step, saturating to the accumulator range
   function automatic logic [ACC_W-1:0] acc_step(input logic [ACC_W-1:0] a,
                                                 input logic [STEP_W-1:0] s,
                                                 input logic sub);
      logic [ACC_W:0] ext_a;
      logic [ACC_W:0] ext_s;
      logic [ACC_W:0] wide;
      ext_a = {a[ACC_W-1], a};
      ext_s = (ACC_W + 1)'(s);
      wide  = sub ? (ext_a - ext_s) : (ext_a + ext_s);
      if (wide[ACC_W] != wide[ACC_W-1]) begin
         return wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end
      return wide[ACC_W-1:0];
   endfunction

   // Strictly positive accumulator
   function automatic logic acc_pos(input logic [ACC_W-1:0] a);
      return !a[ACC_W-1] && (a != '0);
   endfunction

   // Round half up to an integer intensity and clamp to 0..255
   function automatic logic [COLOR_W-1:0] to_byte(input logic [ACC_W-1:0] v);
      logic [ACC_W-1:0]        rnd;
      logic [ACC_W-FRAC_W-1:0] whole;
      rnd   = v + ACC_W'(2 ** (FRAC_W - 1));
      whole = rnd[ACC_W-1:FRAC_W];
      if (v[ACC_W-1]) begin
         return '0;
      end
      if (whole > (ACC_W - FRAC_W)'(COLOR_MAX)) begin
         return COLOR_W'(COLOR_MAX);
      end
      return whole[COLOR_W-1:0];
   endfunction

endpackage

`default_nettype wire

[hw/rtl/alpbm_ctrl.sv]
// ----------------------------------------------------------------------------
// alpbm_ctrl: frame-end sequencer
// Walks one frame-end item through smoothing, decay, the shared divider,
// the color rotation and output load, one operation a cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module alpbm_ctrl
   import alpbm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_frame_end,
   output logic          req_stall,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   ctrl_state_type         state_ff, state_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                   div_last;
   logic                   take;

   assign take     = req_valid && !req_stall;
   assign div_last = (cnt_ff == DIV_CNT_W'(DIV_Q_W - 1));

   // Advance state and divider step count
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Count divider steps, restart outside the division states
   always_comb begin
      if (state_ff == ST_DIV_RATIO || state_ff == ST_DIV_HEIGHT) begin
         cnt_in = cnt_ff + 1'b1;
      end else begin
         cnt_in = '0;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:        if (take && req_frame_end) state_in = ST_EVAL;
         ST_EVAL:        state_in = status.silent ? ST_IDLE : ST_DECAY_MUL;
         ST_DECAY_MUL:   state_in = ST_DECAY_SUB;
         ST_DECAY_SUB:   state_in = ST_LEVEL;
         ST_LEVEL:       state_in = status.quiet ? ST_ROT_R : ST_DIV_CHECK;
         ST_DIV_CHECK:   state_in = status.rec_zero ? ST_STEP_MUL : ST_DIV_RATIO;
         ST_DIV_RATIO:   if (div_last) state_in = ST_SAVE_RATIO;
         ST_SAVE_RATIO:  state_in = ST_DIV_HEIGHT;
         ST_DIV_HEIGHT:  if (div_last) state_in = ST_SAVE_HEIGHT;
         ST_SAVE_HEIGHT: state_in = ST_STEP_MUL;
         ST_STEP_MUL:    state_in = ST_ROT_R;
         ST_ROT_R:       state_in = ST_ROT_G;
         ST_ROT_G:       state_in = ST_ROT_B;
         ST_ROT_B:       state_in = ST_OUT;
         ST_OUT:         if (!status.out_busy) state_in = ST_IDLE;
         default:        state_in = ST_IDLE;
      endcase
   end

   // Outputs: stall and datapath operation
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      cmd.take  = req_valid && (state_ff == ST_IDLE);
      cmd.op    = OP_NONE;
      unique case (state_ff)
         ST_IDLE:        cmd.op = OP_NONE;
         ST_EVAL:        cmd.op = OP_EVAL;
         ST_DECAY_MUL:   cmd.op = OP_DECAY_MUL;
         ST_DECAY_SUB:   cmd.op = OP_DECAY_SUB;
         ST_LEVEL:       cmd.op = OP_LEVEL;
         ST_DIV_CHECK:   cmd.op = status.rec_zero ? OP_ZERO_RATIO : OP_DIV_LOAD;
         ST_DIV_RATIO:   cmd.op = OP_DIV_STEP;
         ST_SAVE_RATIO:  cmd.op = OP_SAVE_RATIO;
         ST_DIV_HEIGHT:  cmd.op = OP_DIV_STEP;
         ST_SAVE_HEIGHT: cmd.op = OP_SAVE_HEIGHT;
         ST_STEP_MUL:    cmd.op = OP_STEP_MUL;
         ST_ROT_R:       cmd.op = OP_ROT_R;
         ST_ROT_G:       cmd.op = OP_ROT_G;
         ST_ROT_B:       cmd.op = OP_ROT_B;
         ST_OUT:         cmd.op = status.out_busy ? OP_NONE : OP_OUT_LOAD;
         default:        cmd.op = OP_NONE;
      endcase
   end

endmodule

`default_nettype wire

[hw/rtl/alpbm_datapath.sv]
// ----------------------------------------------------------------------------
// alpbm_datapath: level meter arithmetic
// Peak tracking, level history, record decay, a restoring divider shared by
// the ratio and the bar height, color accumulators and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module alpbm_datapath
   import alpbm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   output dp_status_type        status,
   input  logic [SAMPLE_W-1:0]  req_sample,
   input  logic                 req_frame_end,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [HEIGHT_W-1:0]  rsp_bar_height,
   output logic [COLOR_W-1:0]   rsp_red_level,
   output logic [COLOR_W-1:0]   rsp_green_level,
   output logic [COLOR_W-1:0]   rsp_blue_level
);

   // Configuration
   logic [CFG_W-1:0]    silence_level_ff, idle_speed_ff, speed_gain_ff, decay_rate_ff;

   // Architectural state
   logic [PEAK_W-1:0]   peak_ff;
   logic [LEVEL_W-1:0]  level_prev_ff, level_older_ff;
   logic [RECORD_W-1:0] record_ff;
   logic [ACC_W-1:0]    red_ff, green_ff, blue_ff;
   logic                rsp_valid_ff;

   // Working registers
   logic [PEAK_W-1:0]   fpeak_ff;
   logic [LEVEL_W-1:0]  smoothed_ff;
   logic [DECAY_W-1:0]  decay_ff;
   logic [DIV_Q_W-1:0]  ratio_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [HEIGHT_W-1:0] height_ff;
   logic [RECORD_W-1:0] rem_ff;
   logic [DIV_Q_W-1:0]  num_ff;
   logic [DIV_Q_W-1:0]  quo_ff;
   logic [HEIGHT_W-1:0] rsp_height_ff;
   logic [COLOR_W-1:0]  rsp_red_ff, rsp_green_ff, rsp_blue_ff;

   // Combinational helpers
   logic [PEAK_W-1:0]    mag;
   logic [PEAK_W-1:0]    peak_max;
   logic [SUM_W-1:0]     level_sum;
   logic [LEVEL_W-1:0]   smoothed_sat;
   logic [DPROD_W-1:0]   decay_prod;
   logic [SPROD_W-1:0]   step_prod;
   logic [DIV_NUM_W-1:0] ratio_num, height_num;
   logic [RECORD_W:0]    div_trial, div_diff;
   logic                 div_ge;
   logic                 red_go, green_go, blue_go;

   // Magnitude of the sample and running peak
   assign mag      = req_sample[SAMPLE_W-1] ? (~req_sample + 1'b1) : req_sample;
   assign peak_max = (mag > peak_ff) ? mag : peak_ff;

   // Smoothed level from peak and two earlier levels
   assign level_sum = SUM_W'(level_older_ff >> 2) + SUM_W'(level_prev_ff >> 1)
                    + SUM_W'({fpeak_ff, 1'b0});
   assign smoothed_sat = level_sum[LEVEL_W] ? '1 : level_sum[LEVEL_W-1:0];

   // One multiplier each for decay and color step
   assign decay_prod = DPROD_W'(decay_rate_ff) * DPROD_W'(smoothed_ff);
   assign step_prod  = SPROD_W'(speed_gain_ff) * SPROD_W'(ratio_ff);

   // Divider numerators and one restoring step
   assign ratio_num  = {smoothed_ff, {FRAC_W{1'b0}}};
   assign height_num = DIV_NUM_W'(smoothed_ff) * DIV_NUM_W'(STRIP_LEDS);
   assign div_trial  = {rem_ff, num_ff[DIV_Q_W-1]};
   assign div_diff   = div_trial - {1'b0, record_ff};
   assign div_ge     = (div_trial >= {1'b0, record_ff});

   // Color rotation conditions
   assign red_go   = acc_pos(red_ff) && !acc_pos(blue_ff);
   assign green_go = acc_pos(green_ff) && !acc_pos(red_ff);
   assign blue_go  = acc_pos(blue_ff) && !acc_pos(green_ff);

   // Status toward the controller
   assign status.silent   = (fpeak_ff == '0) && (level_prev_ff == '0) && (level_older_ff == '0);
   assign status.quiet    = (smoothed_ff < LEVEL_W'(silence_level_ff));
   assign status.rec_zero = (record_ff == '0);
   assign status.out_busy = rsp_valid_ff && rsp_stall;

   // State with reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         silence_level_ff <= SILENCE_LEVEL_RESET;
         idle_speed_ff    <= IDLE_SPEED_RESET;
         speed_gain_ff    <= SPEED_GAIN_RESET;
         decay_rate_ff    <= DECAY_RATE_RESET;
         peak_ff          <= '0;
         level_prev_ff    <= '0;
         level_older_ff   <= '0;
         record_ff        <= '0;
         red_ff           <= ACC_RED_RESET;
         green_ff         <= '0;
         blue_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         // Write configuration
         if (csr_valid) begin
            unique case (csr_index)
               CSR_SILENCE_LEVEL: silence_level_ff <= csr_data;
               CSR_IDLE_SPEED:    idle_speed_ff    <= csr_data;
               CSR_SPEED_GAIN:    speed_gain_ff    <= csr_data;
               CSR_DECAY_RATE:    decay_rate_ff    <= csr_data;
            endcase
         end

         // Track the frame peak, restart after a frame end
         if (cmd.take) begin
            peak_ff <= req_frame_end ? '0 : peak_max;
         end

         unique case (cmd.op)
            OP_EVAL: begin
               if (status.silent) begin
                  record_ff <= '0;
               end else begin
                  level_older_ff <= level_prev_ff;
                  level_prev_ff  <= smoothed_sat;
               end
            end
            OP_DECAY_SUB: begin
               record_ff <= (record_ff > RECORD_W'(decay_ff))
                          ? (record_ff - RECORD_W'(decay_ff)) : '0;
            end
            OP_LEVEL: begin
               if (!status.quiet && (RECORD_W'(smoothed_ff) > record_ff)) begin
                  record_ff <= RECORD_W'(smoothed_ff);
               end
            end
            OP_ROT_R: begin
               if (red_go) begin
                  red_ff   <= acc_step(red_ff, step_ff, 1'b1);
                  green_ff <= acc_step(green_ff, step_ff, 1'b0);
               end
            end
            OP_ROT_G: begin
               if (green_go) begin
                  green_ff <= acc_step(green_ff, step_ff, 1'b1);
                  blue_ff  <= acc_step(blue_ff, step_ff, 1'b0);
               end
            end
            OP_ROT_B: begin
               if (blue_go) begin
                  blue_ff <= acc_step(blue_ff, step_ff, 1'b1);
                  red_ff  <= acc_step(red_ff, step_ff, 1'b0);
               end
            end
            default: begin
            end
         endcase

         // Output register: fill on load, drop when taken
         if (cmd.op == OP_OUT_LOAD) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Working registers and output payload
   always_ff @(posedge clock) begin
      if (cmd.take && req_frame_end) begin
         fpeak_ff <= peak_max;
      end

      unique case (cmd.op)
         OP_EVAL: begin
            smoothed_ff <= smoothed_sat;
         end
         OP_DECAY_MUL: begin
            decay_ff <= decay_prod[DPROD_W-1:DECAY_SHIFT];
         end
         OP_LEVEL: begin
            if (status.quiet) begin
               step_ff   <= idle_speed_ff;
               height_ff <= '0;
            end
         end
         OP_ZERO_RATIO: begin
            ratio_ff  <= '0;
            height_ff <= '0;
         end
         OP_DIV_LOAD: begin
            rem_ff <= RECORD_W'(ratio_num[DIV_NUM_W-1:DIV_Q_W]);
            num_ff <= ratio_num[DIV_Q_W-1:0];
         end
         OP_DIV_STEP: begin
            rem_ff <= div_ge ? div_diff[RECORD_W-1:0] : div_trial[RECORD_W-1:0];
            num_ff <= {num_ff[DIV_Q_W-2:0], 1'b0};
            quo_ff <= {quo_ff[DIV_Q_W-2:0], div_ge};
         end
         OP_SAVE_RATIO: begin
            ratio_ff <= quo_ff;
            rem_ff   <= RECORD_W'(height_num[DIV_NUM_W-1:DIV_Q_W]);
            num_ff   <= height_num[DIV_Q_W-1:0];
         end
         OP_SAVE_HEIGHT: begin
            height_ff <= quo_ff[HEIGHT_W-1:0];
         end
         OP_STEP_MUL: begin
            step_ff <= step_prod[FRAC_W+STEP_W-1:FRAC_W];
         end
         OP_OUT_LOAD: begin
            rsp_height_ff <= height_ff;
            rsp_red_ff    <= to_byte(red_ff);
            rsp_green_ff  <= to_byte(green_ff);
            rsp_blue_ff   <= to_byte(blue_ff);
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_bar_height  = rsp_height_ff;
   assign rsp_red_level   = rsp_red_ff;
   assign rsp_green_level = rsp_green_ff;
   assign rsp_blue_level  = rsp_blue_ff;

endmodule

`default_nettype wire

[hw/rtl/audio_peak_led_bar_meter.sv]
// ----------------------------------------------------------------------------
// audio_peak_led_bar_meter: peak-driven LED bar height and rotating color
// Usage:
//   req_*  : one Q1.15 audio sample per item; req_frame_end marks the last
//            sample of a frame. An item is taken when req_valid is high and
//            req_stall is low.
//   rsp_*  : at most one result per frame end: bar height and an RGB color.
//            Silent frames give no result.
//   csr_*  : register writes (silence level, idle speed, speed gain, decay
//            rate), always ready; write only while the block is idle.
// Timing:
//   A sample without frame end leaves req_stall low. A frame end keeps
//   req_stall high while the sequencer runs: a silent frame stops after
//   evaluation, a quiet frame skips the divider, and a loud frame runs the
//   two 17-step passes of the shared restoring divider (ratio, bar height).
//   Results sit in an output register; samples keep flowing while it waits.
//   If rsp_stall holds a result when the next one is ready, the sequencer
//   waits in its last step until the register frees.
// Reset: synchronous; clears peak, history and record, sets the color to
//   red and loads the default register values.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_peak_led_bar_meter
   import alpbm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [SAMPLE_W-1:0]  req_sample,
   input  logic                 req_frame_end,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [HEIGHT_W-1:0]  rsp_bar_height,
   output logic [COLOR_W-1:0]   rsp_red_level,
   output logic [COLOR_W-1:0]   rsp_green_level,
   output logic [COLOR_W-1:0]   rsp_blue_level,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // Register writes never wait
   assign csr_ready = 1'b1;

   alpbm_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_frame_end (req_frame_end),
      .req_stall     (req_stall),
      .cmd           (cmd),
      .status        (status)
   );

   alpbm_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_sample      (req_sample),
      .req_frame_end   (req_frame_end),
      .csr_valid       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_bar_height  (rsp_bar_height),
      .rsp_red_level   (rsp_red_level),
      .rsp_green_level (rsp_green_level),
      .rsp_blue_level  (rsp_blue_level)
   );

endmodule

`default_nettype wire

[hw/rtl/alpbm_checker.sv]
// ----------------------------------------------------------------------------
// alpbm_checker: port-level checks for the LED bar level meter
// Watches the handshakes and the busy window around frame ends.
// ----------------------------------------------------------------------------
`default_nettype none

module alpbm_checker
   import alpbm_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_stall,
   input wire logic                req_frame_end,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire logic [HEIGHT_W-1:0] rsp_bar_height,
   input wire logic [COLOR_W-1:0]  rsp_red_level,
   input wire logic [COLOR_W-1:0]  rsp_green_level,
   input wire logic [COLOR_W-1:0]  rsp_blue_level
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_bar_height) && $stable(rsp_red_level)
                                 && $stable(rsp_green_level) && $stable(rsp_blue_level))
      else $error("stalled result changed");

   // A frame end starts the sequencer
   a_frame_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_frame_end |=> req_stall)
      else $error("no busy window after a frame end");

   // An ordinary sample keeps the block open
   a_sample_open: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_frame_end |=> !req_stall)
      else $error("stall after an ordinary sample");

   // A new result only appears at the end of a busy window
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared outside frame-end processing");

endmodule

bind audio_peak_led_bar_meter alpbm_checker u_alpbm_checker (.*);

`default_nettype wire
